// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock, off while reset is active
`define DHB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// concurrent assertion that is also checked during reset
`define DHB_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: rtl/dhb_pkg.sv
// shared types and constants for the dual h-bridge command shaper
// no dependencies
package dhb_pkg;

	// field widths
	localparam int CMD_W   = 15;
	localparam int MAG_W   = 14;
	localparam int TIME_W  = 16;
	localparam int PAT_W   = 2;
	localparam int DUTY_W  = 10;
	localparam int OP_W    = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_PAT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PAT = 3'd4;

	// opcodes
	localparam logic [OP_W-1:0] OP_SET_LEFT  = 2'd0;
	localparam logic [OP_W-1:0] OP_SET_RIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK      = 2'd2;
	localparam logic [OP_W-1:0] OP_STOP_ALL  = 2'd3;

	// motor select
	localparam logic MOTOR_LEFT  = 1'b0;
	localparam logic MOTOR_RIGHT = 1'b1;

	// full scale in hundredths of a percent
	localparam int FULL_SCALE = 10000;

	// reset values of the registers
	localparam logic [MAG_W-1:0]  DEADBAND_RST  = 14'd0;
	localparam logic [MAG_W-1:0]  LIMIT_RST     = 14'd10000;
	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 16'd500;
	localparam logic [PAT_W-1:0]  LEFT_PAT_RST  = 2'd1;
	localparam logic [PAT_W-1:0]  RIGHT_PAT_RST = 2'd2;

	// duty scaling: floor(mag * (2^DUTY_BITS - 1) / FULL_SCALE) done as a
	// reciprocal multiply, exact for every magnitude up to full scale
	localparam int DUTY_BITS  = 10;
	localparam int DUTY_SHIFT = 27;
	localparam logic [63:0] DUTY_MULT =
		(((64'd1 << DUTY_BITS) - 64'd1) * (64'd1 << DUTY_SHIFT) + 64'(FULL_SCALE) - 64'd1)
		/ 64'(FULL_SCALE);
	localparam int PROD_W = 48;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	typedef struct packed {
		logic                    motor;
		logic                    bridge_a;
		logic                    bridge_b;
		logic [DUTY_W-1:0]       duty_code;
		logic signed [CMD_W-1:0] applied;
		logic                    last;
	} result_t;

endpackage

// File: rtl/dual_hbridge_command_shaper.sv
// top level of the dual h-bridge command shaper
// depends on dhb_pkg
//
// Takes one request per cycle, while in_stall is low, into an input register;
// on the next edge the shaping logic (deadband, limit, full-scale clamp,
// direction pattern and a single reciprocal multiply for the duty code)
// writes its results into an 8-entry result queue, whose head drives the
// output. A set request makes one result, a stop-all makes two (left then
// right), a tick makes none, one or two depending on which idle counters
// pass the timeout. The output side drains one result per cycle while
// out_stall is low, so the queue sets the sustained rate: one request per
// cycle as long as results leave at least as fast as they are made; in_stall
// rises when the queue could not absorb two more results behind the request
// in the input register. Configuration writes take effect at the next edge.
module dual_hbridge_command_shaper (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wen,
	input  logic [dhb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dhb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dhb_pkg::OP_W-1:0]        opcode,
	input  logic signed [dhb_pkg::CMD_W-1:0] command,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            motor,
	output logic                            bridge_a,
	output logic                            bridge_b,
	output logic [dhb_pkg::DUTY_W-1:0]      duty_code,
	output logic signed [dhb_pkg::CMD_W-1:0] applied,
	output logic                            last
);

	// configuration registers
	logic [dhb_pkg::MAG_W-1:0]  deadband_q;
	logic [dhb_pkg::MAG_W-1:0]  limit_q;
	logic [dhb_pkg::TIME_W-1:0] timeout_q;
	logic [dhb_pkg::PAT_W-1:0]  left_pat_q;
	logic [dhb_pkg::PAT_W-1:0]  right_pat_q;

	// idle counters
	logic [dhb_pkg::TIME_W-1:0] idle_left_q;
	logic [dhb_pkg::TIME_W-1:0] idle_right_q;
	logic [dhb_pkg::TIME_W-1:0] idle_left_inc;
	logic [dhb_pkg::TIME_W-1:0] idle_right_inc;

	// input register
	logic                             valid_s1;
	logic [dhb_pkg::OP_W-1:0]         opcode_s1;
	logic signed [dhb_pkg::CMD_W-1:0] command_s1;

	// shaping
	logic                       set_motor;
	logic                       neg;
	logic [dhb_pkg::CMD_W-1:0]  cmd_bits;
	logic [dhb_pkg::CMD_W-1:0]  mag_raw;
	logic [dhb_pkg::CMD_W-1:0]  mag_db;
	logic [dhb_pkg::CMD_W-1:0]  mag_lim;
	logic [dhb_pkg::CMD_W-1:0]  mag_fs;
	logic [dhb_pkg::MAG_W-1:0]  mag;
	logic [dhb_pkg::PAT_W-1:0]  pat;
	logic [dhb_pkg::PROD_W-1:0] prod;
	logic                       time_left;
	logic                       time_right;

	dhb_pkg::result_t set_res;
	dhb_pkg::result_t stop_left;
	dhb_pkg::result_t stop_right;
	dhb_pkg::result_t res0;
	dhb_pkg::result_t res1;
	logic [1:0]       nres;

	// result queue
	dhb_pkg::result_t            queue_mem [dhb_pkg::QDEPTH];
	logic [dhb_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [dhb_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [dhb_pkg::QCNT_W-1:0]  count_q;
	logic [dhb_pkg::QCNT_W:0]    occupancy;
	logic                        pop;
	logic                        in_take;

	assign in_take = in_valid && !in_stall;
	assign pop     = out_valid && !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= dhb_pkg::DEADBAND_RST;
			limit_q     <= dhb_pkg::LIMIT_RST;
			timeout_q   <= dhb_pkg::TIMEOUT_RST;
			left_pat_q  <= dhb_pkg::LEFT_PAT_RST;
			right_pat_q <= dhb_pkg::RIGHT_PAT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dhb_pkg::REG_DEADBAND:  deadband_q  <= cfg_data[dhb_pkg::MAG_W-1:0];
				dhb_pkg::REG_LIMIT:     limit_q     <= cfg_data[dhb_pkg::MAG_W-1:0];
				dhb_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[dhb_pkg::TIME_W-1:0];
				dhb_pkg::REG_LEFT_PAT:  left_pat_q  <= cfg_data[dhb_pkg::PAT_W-1:0];
				dhb_pkg::REG_RIGHT_PAT: right_pat_q <= cfg_data[dhb_pkg::PAT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1  <= opcode;
			command_s1 <= command;
		end
	end

	// magnitude shaping: deadband, then limit, then full scale
	assign set_motor = (opcode_s1 == dhb_pkg::OP_SET_RIGHT);
	assign cmd_bits  = command_s1;
	assign neg       = command_s1[dhb_pkg::CMD_W-1];
	assign mag_raw   = neg ? (~cmd_bits + 15'd1) : cmd_bits;
	assign mag_db    = (mag_raw < {1'b0, deadband_q}) ? {1'b0, deadband_q} : mag_raw;
	assign mag_lim   = (mag_db > {1'b0, limit_q}) ? {1'b0, limit_q} : mag_db;
	assign mag_fs    = (mag_lim > 15'(dhb_pkg::FULL_SCALE)) ?
		15'(dhb_pkg::FULL_SCALE) : mag_lim;
	assign mag       = (mag_raw == '0) ? '0 : mag_fs[dhb_pkg::MAG_W-1:0];

	// direction pattern and duty scaling
	always_comb begin
		pat = (set_motor == dhb_pkg::MOTOR_RIGHT) ? right_pat_q : left_pat_q;
		if (neg) begin
			pat = ~pat;
		end
	end

	assign prod = dhb_pkg::PROD_W'(mag) * dhb_pkg::DUTY_MULT[dhb_pkg::PROD_W-1:0];

	// result of a set request; a magnitude that shapes to zero stops the motor
	always_comb begin
		set_res.motor = set_motor;
		set_res.last  = 1'b1;
		if (mag == '0) begin
			set_res.bridge_a  = 1'b0;
			set_res.bridge_b  = 1'b0;
			set_res.duty_code = '0;
			set_res.applied   = '0;
		end else begin
			set_res.bridge_a  = pat[0];
			set_res.bridge_b  = pat[1];
			set_res.duty_code = prod[dhb_pkg::DUTY_SHIFT +: dhb_pkg::DUTY_W];
			set_res.applied   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	// stop results
	always_comb begin
		stop_left           = '0;
		stop_left.motor     = dhb_pkg::MOTOR_LEFT;
		stop_right          = '0;
		stop_right.motor    = dhb_pkg::MOTOR_RIGHT;
		stop_right.last     = 1'b1;
	end

	// saturating idle counter increments and timeout check
	assign idle_left_inc  = (idle_left_q == '1) ? idle_left_q : idle_left_q + 16'd1;
	assign idle_right_inc = (idle_right_q == '1) ? idle_right_q : idle_right_q + 16'd1;
	assign time_left      = idle_left_inc > timeout_q;
	assign time_right     = idle_right_inc > timeout_q;

	// results made by the request in the input register
	always_comb begin
		res0 = stop_left;
		res1 = stop_right;
		nres = 2'd0;
		case (opcode_s1)
			dhb_pkg::OP_SET_LEFT, dhb_pkg::OP_SET_RIGHT: begin
				res0 = set_res;
				nres = 2'd1;
			end
			dhb_pkg::OP_STOP_ALL: begin
				nres = 2'd2;
			end
			dhb_pkg::OP_TICK: begin
				if (time_left && time_right) begin
					nres = 2'd2;
				end else if (time_left) begin
					res0.last = 1'b1;
					nres      = 2'd1;
				end else if (time_right) begin
					res0 = stop_right;
					nres = 2'd1;
				end
			end
			default: ;
		endcase
	end

	// idle counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_left_q  <= '0;
			idle_right_q <= '0;
		end else if (valid_s1) begin
			case (opcode_s1)
				dhb_pkg::OP_SET_LEFT:  idle_left_q  <= '0;
				dhb_pkg::OP_SET_RIGHT: idle_right_q <= '0;
				dhb_pkg::OP_TICK: begin
					idle_left_q  <= time_left ? '0 : idle_left_inc;
					idle_right_q <= time_right ? '0 : idle_right_inc;
				end
				default: ;
			endcase
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s1 && nres != 2'd0) begin
			queue_mem[wr_ptr_q] <= res0;
		end
		if (valid_s1 && nres == 2'd2) begin
			queue_mem[wr_ptr_q + 3'd1] <= res1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + dhb_pkg::QPTR_W'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 3'd1;
			end
			count_q <= count_q + (valid_s1 ? dhb_pkg::QCNT_W'(nres) : '0)
				- dhb_pkg::QCNT_W'(pop);
		end
	end

	// room for two more results behind the request in flight
	assign occupancy = {1'b0, count_q} + (valid_s1 ? 5'd2 : 5'd0);
	assign in_stall  = occupancy > 5'(dhb_pkg::QDEPTH - 2);

	// output from the queue head
	assign out_valid = count_q != '0;
	assign motor     = queue_mem[rd_ptr_q].motor;
	assign bridge_a  = queue_mem[rd_ptr_q].bridge_a;
	assign bridge_b  = queue_mem[rd_ptr_q].bridge_b;
	assign duty_code = queue_mem[rd_ptr_q].duty_code;
	assign applied   = queue_mem[rd_ptr_q].applied;
	assign last      = queue_mem[rd_ptr_q].last;

endmodule

// File: rtl/dhb_checker.sv
// port-level checks for the dual h-bridge command shaper, bound to the top level
// depends on dhb_pkg and assert_macros.svh
`include "assert_macros.svh"

module dhb_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             motor,
	input  logic                             bridge_a,
	input  logic                             bridge_b,
	input  logic [dhb_pkg::DUTY_W-1:0]       duty_code,
	input  logic signed [dhb_pkg::CMD_W-1:0] applied,
	input  logic                             last
);

	localparam logic signed [dhb_pkg::CMD_W-1:0] FS_POS = 15'(dhb_pkg::FULL_SCALE);
	localparam logic signed [dhb_pkg::CMD_W-1:0] FS_NEG = -15'(dhb_pkg::FULL_SCALE);

	logic fully_off;
	logic in_range;

	assign fully_off = duty_code == '0 && !bridge_a && !bridge_b;
	assign in_range  = applied <= FS_POS && applied >= FS_NEG;

	// a stalled result stays offered
	`DHB_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped")

	// a stopped motor has both bridge inputs low and no duty
	`DHB_ASSERT(a_stop_shape, clk, arst_n, out_valid && applied == '0 |-> fully_off, "stop not off")

	// the right motor result always closes its request
	`DHB_ASSERT(a_right_last, clk, arst_n, out_valid && motor |-> last, "right without last")

	// applied value stays within full scale
	`DHB_ASSERT(a_applied_range, clk, arst_n, out_valid |-> in_range, "applied beyond full scale")

	// reset empties the result side
	`DHB_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result offered after reset")

endmodule

bind dual_hbridge_command_shaper dhb_checker u_dhb_checker (.*);
